>>> hdl/snsw_pkg.sv
// Shared types and constants for the sequence number sliding window.
package snsw_pkg;

	localparam int unsigned WINDOW_MAX_DEF  = 64;
	localparam int unsigned SEQ_W           = 16;
	localparam int unsigned WSIZE_W         = 7;
	localparam int unsigned COUNT_OUT_W     = 7;
	localparam int unsigned STATUS_W        = 2;
	localparam int unsigned APB_ADDR_W      = 3;
	localparam int unsigned APB_DATA_W      = 32;
	localparam int unsigned REG_WIN_SPAN    = 0;
	localparam logic [WSIZE_W-1:0] WIN_SPAN_RST = 7'd64;

	typedef enum logic [STATUS_W-1:0] {
		ST_ADDED = 2'd0,
		ST_DUP   = 2'd1,
		ST_OLD   = 2'd2
	} status_t;

	// per-cycle command broadcast to every bitmap cell
	typedef struct packed {
		logic load_first;
		logic add_behind;
		logic add_ahead;
	} cell_ctrl_t;

endpackage

>>> hdl/snsw_cell.sv
// One bitmap cell: holds the seen flag for offset IDX behind the newest number.
module snsw_cell
	import snsw_pkg::*;
#(
	parameter int unsigned WINDOW_MAX = WINDOW_MAX_DEF,
	parameter int unsigned IDX        = 0,
	localparam int unsigned IW        = $clog2(WINDOW_MAX),
	localparam int unsigned WW        = $clog2(WINDOW_MAX + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  cell_ctrl_t    ctrl,
	input  logic [IW-1:0] d_idx,
	input  logic [WW-1:0] w_eff,
	input  logic          src_bit,
	output logic          q
);

	logic is_zero;
	logic is_d;
	logic keep;

	assign is_zero = (IDX == 0);
	assign is_d    = (d_idx == IW'(IDX));
	assign keep    = (WW'(IDX) < w_eff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q <= 1'b0;
		end else if (ctrl.load_first) begin
			q <= is_zero;
		end else if (ctrl.add_behind) begin
			q <= (q | is_d) & keep;
		end else if (ctrl.add_ahead) begin
			q <= (src_bit | is_zero) & keep;
		end
	end

endmodule

>>> hdl/snsw_popcount.sv
// Three-stage registered population count over the bitmap cells.
module snsw_popcount
	import snsw_pkg::*;
#(
	parameter int unsigned WINDOW_MAX = WINDOW_MAX_DEF,
	localparam int unsigned CNTW      = $clog2(WINDOW_MAX + 1),
	localparam int unsigned G1        = (WINDOW_MAX + 7) / 8,
	localparam int unsigned G2        = (G1 + 7) / 8
) (
	input  logic                  clk,
	input  logic                  en,
	input  logic [WINDOW_MAX-1:0] bits,
	output logic [CNTW-1:0]       count_s4
);

	logic [3:0]      grp_s2  [G1];
	logic [CNTW-1:0] part_s3 [G2];
	logic [3:0]      grp_d   [G1];
	logic [CNTW-1:0] part_d  [G2];
	logic [CNTW-1:0] total_d;

	// groups of eight cells
	always_comb begin
		for (int g = 0; g < G1; g++) begin
			grp_d[g] = 4'd0;
			for (int j = 0; j < 8; j++) begin
				if (g * 8 + j < WINDOW_MAX) begin
					grp_d[g] = grp_d[g] + {3'd0, bits[g * 8 + j]};
				end
			end
		end
	end

	// groups of eight group counts
	always_comb begin
		for (int g = 0; g < G2; g++) begin
			part_d[g] = '0;
			for (int j = 0; j < 8; j++) begin
				if (g * 8 + j < G1) begin
					part_d[g] = part_d[g] + CNTW'(grp_s2[g * 8 + j]);
				end
			end
		end
	end

	// sum of the partial sums left
	always_comb begin
		total_d = '0;
		for (int g = 0; g < G2; g++) begin
			total_d = total_d + part_s3[g];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			grp_s2   <= grp_d;
			part_s3  <= part_d;
			count_s4 <= total_d;
		end
	end

endmodule

>>> hdl/sequence_number_sliding_window_top.sv
// Anti-replay sliding window: a row of bitmap cells plus a registered count pipeline.
// Result path: classify in s1, popcount registers in s2 to s4; s4 drives the outputs.
// One item per cycle while no result waits untaken; the cell row updates in the accept cycle.
// The whole pipeline holds while a result waits; in_ready follows out_ready.
// Reset (arst_n low, asynchronous): bitmap empty, newest zero, win_span 64,
// no item in flight.
module sequence_number_sliding_window_top
	import snsw_pkg::*;
#(
	parameter int unsigned WINDOW_MAX = WINDOW_MAX_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// input items
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [SEQ_W-1:0]       seq_num,
	// result items
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [STATUS_W-1:0]    status,
	output logic [COUNT_OUT_W-1:0] member_count,
	output logic [SEQ_W-1:0]       newest_seq,
	// configuration
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [APB_ADDR_W-1:0]  paddr,
	input  logic [APB_DATA_W-1:0]  pwdata,
	output logic [APB_DATA_W-1:0]  prdata,
	output logic                   pready
);

	localparam int unsigned IW   = $clog2(WINDOW_MAX);
	localparam int unsigned WW   = $clog2(WINDOW_MAX + 1);
	localparam int unsigned CNTW = $clog2(WINDOW_MAX + 1);
	localparam int unsigned CW   = (WW > WSIZE_W) ? WW : WSIZE_W;

	// ---------------- configuration ----------------
	logic [WSIZE_W-1:0] win_span_q;
	logic               reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = (paddr[2] == 1'(REG_WIN_SPAN));
	assign prdata  = reg_sel ? APB_DATA_W'(win_span_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_span_q <= WIN_SPAN_RST;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			win_span_q <= pwdata[WSIZE_W-1:0];
		end
	end

	// Effective window: zero reads as one, anything above the bitmap depth
	// is capped at the depth.
	logic [CW-1:0] ws_ext;
	logic [WW-1:0] w_eff;

	assign ws_ext = CW'(win_span_q);
	always_comb begin
		if (ws_ext == '0) begin
			w_eff = WW'(1);
		end else if (ws_ext > CW'(WINDOW_MAX)) begin
			w_eff = WW'(WINDOW_MAX);
		end else begin
			w_eff = WW'(ws_ext);
		end
	end

	// ---------------- handshake ----------------
	// One enable moves every stage; the pipeline only stops when the
	// output register holds an item nobody takes.
	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic en;
	logic accept;

	assign en        = !valid_s4 || out_ready;
	assign in_ready  = en;
	assign accept    = in_valid && en;
	assign out_valid = valid_s4;

	// ---------------- classification ----------------
	logic [SEQ_W-1:0]      newest_q;
	logic                  not_empty_q;
	logic [WINDOW_MAX-1:0] bits;
	logic [SEQ_W-1:0]      d_dist;   // how far seq_num lags newest
	logic [SEQ_W-1:0]      s_dist;   // how far seq_num leads newest
	logic [SEQ_W:0]        d17, w17;
	logic                  too_old, behind, hit;
	logic [IW-1:0]         d_idx;
	logic [WINDOW_MAX-1:0] shifted;
	cell_ctrl_t            ctrl;
	status_t               status_d;
	logic [SEQ_W-1:0]      newest_d;

	assign d_dist  = newest_q - seq_num;
	assign s_dist  = seq_num - newest_q;
	assign d17     = {1'b0, d_dist};
	assign w17     = (SEQ_W + 1)'(w_eff);
	// Lagging by W up to W + 32767 is too old; the
	// same test also rejects numbers that are implausibly far ahead.
	assign too_old = (d17 >= w17) && (d17 < w17 + 17'd32768);
	assign behind  = (d17 < w17);
	assign d_idx   = d_dist[IW-1:0];
	assign hit     = behind && bits[d_idx];

	// Moving the anchor forward: each cell takes the flag that sits s_dist
	// cells below it; a jump past the whole bitmap empties it.
	assign shifted = (s_dist < SEQ_W'(WINDOW_MAX)) ? (bits << s_dist[IW-1:0]) : '0;

	always_comb begin
		ctrl.load_first = accept && !not_empty_q;
		ctrl.add_behind = accept && not_empty_q && behind && !hit;
		ctrl.add_ahead  = accept && not_empty_q && !too_old && !behind;
	end

	always_comb begin
		if (!not_empty_q) begin
			status_d = ST_ADDED;
		end else if (too_old) begin
			status_d = ST_OLD;
		end else if (hit) begin
			status_d = ST_DUP;
		end else begin
			status_d = ST_ADDED;
		end
	end

	assign newest_d = (ctrl.load_first || ctrl.add_ahead) ? seq_num : newest_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			newest_q    <= '0;
			not_empty_q <= 1'b0;
		end else if (accept) begin
			newest_q    <= newest_d;
			not_empty_q <= 1'b1;
		end
	end

	// ---------------- cell row ----------------
	// Cell k holds "newest - k has been seen".
	for (genvar k = 0; k < WINDOW_MAX; k++) begin : g_cell
		snsw_cell #(
			.WINDOW_MAX(WINDOW_MAX),
			.IDX       (k)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (ctrl),
			.d_idx  (d_idx),
			.w_eff  (w_eff),
			.src_bit(shifted[k]),
			.q      (bits[k])
		);
	end

	// ---------------- result pipeline ----------------
	// Stage 1 is the accept cycle's result; the count of the bitmap it left
	// behind is taken over the next three stages while the row keeps working.
	status_t          status_s1, status_s2, status_s3, status_s4;
	logic [SEQ_W-1:0] newest_s1, newest_s2, newest_s3, newest_s4;
	logic [CNTW-1:0]  count_s4;

	snsw_popcount #(
		.WINDOW_MAX(WINDOW_MAX)
	) u_popcount (
		.clk     (clk),
		.en      (en),
		.bits    (bits),
		.count_s4(count_s4)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			status_s1 <= status_d;
			newest_s1 <= newest_d;
			status_s2 <= status_s1;
			newest_s2 <= newest_s1;
			status_s3 <= status_s2;
			newest_s3 <= newest_s2;
			status_s4 <= status_s3;
			newest_s4 <= newest_s3;
		end
	end

	assign status       = status_s4;
	assign newest_seq   = newest_s4;
	assign member_count = COUNT_OUT_W'(count_s4);   // reported modulo 128

endmodule

>>> hdl/snsw_checker.sv
// Port-level checks for the sliding window top, bound to every instance.
module snsw_checker
	import snsw_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_ready,
	input logic                   out_valid,
	input logic                   out_ready,
	input logic [STATUS_W-1:0]    status,
	input logic [COUNT_OUT_W-1:0] member_count,
	input logic [SEQ_W-1:0]       newest_seq
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) &&
			$stable(member_count) && $stable(newest_seq))
		else $error("result changed while stalled");

	// a stalled result blocks the input side
	a_stall_back: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while output stalled");

	// the newest number is always held once any item went through
	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> member_count != '0)
		else $error("empty window reported");

	// no status code beyond rejected
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == ST_ADDED || status == ST_DUP || status == ST_OLD))
		else $error("bad status code");

endmodule

bind sequence_number_sliding_window_top snsw_checker u_snsw_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.status      (status),
	.member_count(member_count),
	.newest_seq  (newest_seq)
);
